@@ rtl/core/assert_macros.svh @@
// Assertion macros shared by the allocator RTL.
// Used by the top level; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define AST_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication, disabled while reset is asserted
`define AST_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

@@ rtl/core/gbba_pkg.sv @@
// Package for the grouped bitmap block allocator: payload structs,
// status and command codes, sequencer states and the walker op struct.
// No dependencies.
`default_nettype none

package gbba_pkg;

    localparam int ID_W  = 14;
    localparam int CFG_W = 5;
    localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

    // Command codes
    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_ZERO_HINT = 2'd2,
        ST_RANGE     = 2'd3
    } t_status;

    typedef struct packed {
        logic            cmd;
        logic            first_alloc;
        logic [ID_W-1:0] hint_block;
        logic [ID_W-1:0] freed_block;
    } t_req;

    typedef struct packed {
        logic [ID_W-1:0] block_id;
        t_status         status;
    } t_rsp;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_LOCATE,
        S_MINSCAN,
        S_HUNT,
        S_WLOAD,
        S_WSCAN
    } t_state;

    // Control to the group walker; restore wins over zero, zero over step
    typedef struct packed {
        logic zero;
        logic step;
        logic mark;
        logic restore;
    } t_walk_op;

endpackage

`default_nettype wire

@@ rtl/core/gbba_walk.sv @@
// Group walker: tracks group index, group start bit address, and the word
// index/offset of that start, advancing one group per step.
// Depends on gbba_pkg.
`default_nettype none

module gbba_walk #(
    parameter int GROUPS           = 16,
    parameter int BLOCKS_PER_GROUP = 1024,
    parameter int WORD_BITS        = 32,
    localparam int TW   = (GROUPS * BLOCKS_PER_GROUP + WORD_BITS - 1) / WORD_BITS,
    localparam int GCW  = $clog2(GROUPS + 1),
    localparam int AW   = $clog2(GROUPS * BLOCKS_PER_GROUP + 1),
    localparam int WAW  = (TW > 1) ? $clog2(TW) : 1,
    localparam int BW   = $clog2(WORD_BITS)
) (
    input  wire                 i_clk,
    input  gbba_pkg::t_walk_op  i_op,
    output logic [GCW-1:0]      o_g,
    output logic [GCW-1:0]      o_g_nxt,
    output logic [AW-1:0]       o_base,
    output logic [WAW-1:0]      o_wbase,
    output logic [BW-1:0]       o_rem
);
    import gbba_pkg::*;

    localparam int WSTEP = BLOCKS_PER_GROUP / WORD_BITS;
    localparam int RSTEP = BLOCKS_PER_GROUP % WORD_BITS;

    logic [GCW-1:0] r_g,     n_g,     r_mg;
    logic [AW-1:0]  r_base,  n_base,  r_mbase;
    logic [WAW-1:0] r_wbase, n_wbase, r_mwbase;
    logic [BW-1:0]  r_rem,   n_rem,   r_mrem;
    logic [BW:0]    rsum;
    logic           carry;

    // Next position
    always_comb begin
        rsum  = (BW+1)'(r_rem) + (BW+1)'(RSTEP);
        carry = (rsum >= (BW+1)'(WORD_BITS));
        n_g     = r_g;
        n_base  = r_base;
        n_wbase = r_wbase;
        n_rem   = r_rem;
        if (i_op.restore) begin
            n_g     = r_mg;
            n_base  = r_mbase;
            n_wbase = r_mwbase;
            n_rem   = r_mrem;
        end else if (i_op.zero) begin
            n_g     = '0;
            n_base  = '0;
            n_wbase = '0;
            n_rem   = '0;
        end else if (i_op.step) begin
            n_g     = r_g + GCW'(1);
            n_base  = r_base + AW'(BLOCKS_PER_GROUP);
            n_wbase = r_wbase + WAW'(WSTEP) + WAW'(carry);
            n_rem   = carry ? BW'(rsum - (BW+1)'(WORD_BITS)) : BW'(rsum);
        end
    end

    // Position and saved mark
    always_ff @(posedge i_clk) begin
        r_g     <= n_g;
        r_base  <= n_base;
        r_wbase <= n_wbase;
        r_rem   <= n_rem;
        if (i_op.mark) begin
            r_mg     <= r_g;
            r_mbase  <= r_base;
            r_mwbase <= r_wbase;
            r_mrem   <= r_rem;
        end
    end

    assign o_g     = r_g;
    assign o_g_nxt = n_g;
    assign o_base  = r_base;
    assign o_wbase = r_wbase;
    assign o_rem   = r_rem;

endmodule

`default_nettype wire

@@ rtl/core/gbba_bitfind.sv @@
// Finds the lowest clear bit of a bitmap word inside a bit window [lo, hi).
// Depends on gbba_pkg.
`default_nettype none

module gbba_bitfind #(
    parameter int WORD_BITS = 32,
    localparam int BW = $clog2(WORD_BITS)
) (
    input  wire [WORD_BITS-1:0] i_word,
    input  wire [BW:0]          i_lo,
    input  wire [BW:0]          i_hi,
    output logic                o_found,
    output logic [BW-1:0]       o_idx
);
    import gbba_pkg::*;

    // Priority pick from the top down so the lowest eligible bit wins
    always_comb begin
        o_found = 1'b0;
        o_idx   = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (!i_word[i] && ((BW+1)'(i) >= i_lo) && ((BW+1)'(i) < i_hi)) begin
                o_found = 1'b1;
                o_idx   = BW'(i);
            end
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/grouped_bitmap_block_allocator.sv @@
// Grouped bitmap block allocator, top level: sequencer, bitmap and count memories.
// Depends on gbba_pkg, gbba_walk, gbba_bitfind and assert_macros.svh.
//
// Takes one request at a time: start is sampled while busy is low. The one result
// appears on o_rsp with o_valid high for a single cycle, the first cycle in which
// busy is low again. There is no back-pressure, so the receiver must take it then.
// The group walker advances one group per cycle and the bitmap is read one word per
// cycle, which sets the latency. A free walks the groups to the one that holds the
// freed block, then scans its words up to the block's word. A hinted allocate walks
// the groups to the one that holds the hint, then searches the groups cyclically
// from there for one with free blocks, then scans that group's words. A first
// allocate visits each group in use for the least-free pick, reloads when the pick
// is not the last group, then scans the words. A zero hint answers in the cycle
// after start without going busy. After reset the block clears its memories with
// busy high. The user must write group_count only while idle; the block itself
// does not enforce it. The write channel is always ready.
`default_nettype none

module grouped_bitmap_block_allocator #(
    parameter int GROUPS           = 16,
    parameter int BLOCKS_PER_GROUP = 1024,
    parameter int WORD_BITS        = 32
) (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               start,
    output logic                              busy,
    input  gbba_pkg::t_req                    i_req,
    output gbba_pkg::t_rsp                    o_rsp,
    output logic                              o_valid,
    input  wire                               i_cfg_valid,
    output logic                              o_cfg_ready,
    input  wire [gbba_pkg::CFG_W-1:0]         i_cfg_data
);
    import gbba_pkg::*;

`include "assert_macros.svh"

    localparam int TW   = (GROUPS * BLOCKS_PER_GROUP + WORD_BITS - 1) / WORD_BITS;
    localparam int GW   = (GROUPS > 1) ? $clog2(GROUPS) : 1;
    localparam int GCW  = $clog2(GROUPS + 1);
    localparam int AW   = $clog2(GROUPS * BLOCKS_PER_GROUP + 1);
    localparam int WAW  = (TW > 1) ? $clog2(TW) : 1;
    localparam int BW   = $clog2(WORD_BITS);
    localparam int CW   = $clog2(BLOCKS_PER_GROUP + 1);
    localparam int CMPW = ((AW > ID_W) ? AW : ID_W) + 1;
    localparam int CLRN = (TW > GROUPS) ? TW : GROUPS;
    localparam int CLRW = (CLRN > 1) ? $clog2(CLRN) : 1;

    // State
    t_state              r_state, n_state;
    t_req                r_req,   n_req;
    t_rsp                r_rsp,   n_rsp;
    logic                r_valid, n_valid;
    logic [CFG_W-1:0]    r_group_count;
    logic [CLRW-1:0]     r_clr,   n_clr;
    logic [WAW-1:0]      r_w,     n_w;
    logic [AW-1:0]       r_wa,    n_wa;
    logic [CW-1:0]       r_best,  n_best;
    logic [GCW-1:0]      r_k,     n_k;

    // Memories and read data
    logic [WORD_BITS-1:0] bm_mem [TW];
    logic [CW-1:0]        cnt_mem [GROUPS];
    logic [WORD_BITS-1:0] r_word_q;
    logic [CW-1:0]        r_cnt_q;
    logic                 bm_we;
    logic [WAW-1:0]       bm_waddr;
    logic [WORD_BITS-1:0] bm_wdata;
    logic                 cnt_we;
    logic [GW-1:0]        cnt_waddr;
    logic [CW-1:0]        cnt_wdata;

    // Walker
    t_walk_op            wop;
    logic [GCW-1:0]      w_g, w_g_nxt;
    logic [AW-1:0]       w_base;
    logic [WAW-1:0]      w_wbase;
    logic [BW-1:0]       w_rem;

    // Datapath helpers
    logic [GCW-1:0]       gc;
    logic [CMPW-1:0]      key_ext, base_ext, end_ext, wa_ext, wa_top, id_sum;
    logic [CMPW-1:0]      lo_diff, hi_diff;
    logic [BW:0]          win_lo, win_hi;
    logic                 fd_found;
    logic [BW-1:0]        fd_idx, fr_idx;
    logic [WORD_BITS-1:0] bit_sel, fr_sel;
    logic                 take, last_g, wrap_g;
    logic [CW-1:0]        best_cnt;
    logic                 accept;

    // Check terms
    logic                 zh_acc, run_acc, rsp_fail;

    gbba_walk #(
        .GROUPS           (GROUPS),
        .BLOCKS_PER_GROUP (BLOCKS_PER_GROUP),
        .WORD_BITS        (WORD_BITS)
    ) u_walk (
        .i_clk   (i_clk),
        .i_op    (wop),
        .o_g     (w_g),
        .o_g_nxt (w_g_nxt),
        .o_base  (w_base),
        .o_wbase (w_wbase),
        .o_rem   (w_rem)
    );

    gbba_bitfind #(
        .WORD_BITS (WORD_BITS)
    ) u_find (
        .i_word  (r_word_q),
        .i_lo    (win_lo),
        .i_hi    (win_hi),
        .o_found (fd_found),
        .o_idx   (fd_idx)
    );

    // Effective group count: 0 acts as 1, clamp to GROUPS
    always_comb begin
        if (r_group_count == '0) begin
            gc = GCW'(1);
        end else if (int'(r_group_count) > GROUPS) begin
            gc = GCW'(GROUPS);
        end else begin
            gc = GCW'(r_group_count);
        end
    end

    // Address arithmetic for group location and the word scan window
    always_comb begin
        key_ext  = (r_req.cmd == CMD_FREE) ? CMPW'(r_req.freed_block)
                                           : CMPW'(r_req.hint_block);
        base_ext = CMPW'(w_base);
        end_ext  = base_ext + CMPW'(BLOCKS_PER_GROUP);
        wa_ext   = CMPW'(r_wa);
        wa_top   = wa_ext + CMPW'(WORD_BITS);
        lo_diff  = (base_ext > wa_ext) ? (base_ext - wa_ext) : '0;
        hi_diff  = end_ext - wa_ext;
        win_lo   = (BW+1)'(lo_diff);
        win_hi   = (hi_diff >= CMPW'(WORD_BITS)) ? (BW+1)'(WORD_BITS) : (BW+1)'(hi_diff);
        id_sum   = wa_ext + CMPW'(fd_idx);
        fr_idx   = BW'(key_ext - wa_ext);
        bit_sel  = WORD_BITS'(1) << fd_idx;
        fr_sel   = WORD_BITS'(1) << fr_idx;
        take     = (w_g == '0) || (r_cnt_q < r_best);
        last_g   = (w_g == (gc - GCW'(1)));
        wrap_g   = ((w_g + GCW'(1)) == gc);
        best_cnt = take ? r_cnt_q : r_best;
    end

    assign accept      = start && !busy;
    assign busy        = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_rsp       = r_rsp;
    assign o_valid     = r_valid;

    // Sequencer: next state, walker control, memory writes
    always_comb begin
        n_state   = r_state;
        n_req     = r_req;
        n_rsp     = r_rsp;
        n_valid   = 1'b0;
        n_clr     = r_clr;
        n_w       = r_w;
        n_wa      = r_wa;
        n_best    = r_best;
        n_k       = r_k;
        wop       = '0;
        bm_we     = 1'b0;
        bm_waddr  = r_w;
        bm_wdata  = r_word_q;
        cnt_we    = 1'b0;
        cnt_waddr = w_g[GW-1:0];
        cnt_wdata = r_cnt_q;

        case (r_state)
            S_CLEAR: begin
                // One word and one count per cycle
                bm_we     = (int'(r_clr) < TW);
                bm_waddr  = WAW'(r_clr);
                bm_wdata  = '0;
                cnt_we    = (int'(r_clr) < GROUPS);
                cnt_waddr = GW'(r_clr);
                cnt_wdata = CW'(BLOCKS_PER_GROUP);
                if (int'(r_clr) == CLRN - 1) begin
                    n_state = S_IDLE;
                end else begin
                    n_clr = r_clr + CLRW'(1);
                end
            end

            S_IDLE: begin
                if (accept) begin
                    n_req = i_req;
                    if (i_req.cmd == CMD_FREE) begin
                        wop.zero = 1'b1;
                        n_state  = S_LOCATE;
                    end else if (i_req.first_alloc) begin
                        wop.zero = 1'b1;
                        n_state  = S_MINSCAN;
                    end else if (i_req.hint_block == '0) begin
                        n_valid = 1'b1;
                        n_rsp   = '{block_id: '0, status: ST_ZERO_HINT};
                    end else begin
                        wop.zero = 1'b1;
                        n_state  = S_LOCATE;
                    end
                end
            end

            S_LOCATE: begin
                // Walk groups until the key falls inside one
                if (w_g >= gc) begin
                    n_valid = 1'b1;
                    n_rsp   = '{block_id: '0, status: ST_RANGE};
                    n_state = S_IDLE;
                end else if (key_ext < end_ext) begin
                    if (r_req.cmd == CMD_FREE) begin
                        n_w     = w_wbase;
                        n_wa    = w_base - AW'(w_rem);
                        n_state = S_WSCAN;
                    end else begin
                        n_k     = '0;
                        n_state = S_HUNT;
                    end
                end else begin
                    wop.step = 1'b1;
                end
            end

            S_MINSCAN: begin
                // Least-free group, first on ties
                if (!last_g) begin
                    wop.step = 1'b1;
                    wop.mark = take;
                    if (take) begin
                        n_best = r_cnt_q;
                    end
                end else if (best_cnt == '0) begin
                    n_valid = 1'b1;
                    n_rsp   = '{block_id: '0, status: ST_FULL};
                    n_state = S_IDLE;
                end else if (take) begin
                    n_w     = w_wbase;
                    n_wa    = w_base - AW'(w_rem);
                    n_state = S_WSCAN;
                end else begin
                    wop.restore = 1'b1;
                    n_state     = S_WLOAD;
                end
            end

            S_HUNT: begin
                // Cyclic search for a group with free blocks
                if (r_cnt_q != '0) begin
                    n_w     = w_wbase;
                    n_wa    = w_base - AW'(w_rem);
                    n_state = S_WSCAN;
                end else if (r_k == (gc - GCW'(1))) begin
                    n_valid = 1'b1;
                    n_rsp   = '{block_id: '0, status: ST_FULL};
                    n_state = S_IDLE;
                end else begin
                    n_k = r_k + GCW'(1);
                    if (wrap_g) begin
                        wop.zero = 1'b1;
                    end else begin
                        wop.step = 1'b1;
                    end
                end
            end

            S_WLOAD: begin
                n_w     = w_wbase;
                n_wa    = w_base - AW'(w_rem);
                n_state = S_WSCAN;
            end

            S_WSCAN: begin
                if (r_req.cmd == CMD_FREE) begin
                    // Clear the bit once its word is reached
                    if (key_ext < wa_top) begin
                        if ((r_word_q & fr_sel) != '0) begin
                            bm_we     = 1'b1;
                            bm_wdata  = r_word_q & ~fr_sel;
                            cnt_we    = 1'b1;
                            cnt_wdata = r_cnt_q + CW'(1);
                        end
                        n_valid = 1'b1;
                        n_rsp   = '{block_id: '0, status: ST_OK};
                        n_state = S_IDLE;
                    end else begin
                        n_w  = r_w + WAW'(1);
                        n_wa = r_wa + AW'(WORD_BITS);
                    end
                end else if (fd_found) begin
                    bm_we     = 1'b1;
                    bm_wdata  = r_word_q | bit_sel;
                    cnt_we    = 1'b1;
                    cnt_wdata = r_cnt_q - CW'(1);
                    n_valid   = 1'b1;
                    n_rsp     = '{block_id: id_sum[ID_W-1:0], status: ST_OK};
                    n_state   = S_IDLE;
                end else if (wa_top >= end_ext) begin
                    n_valid = 1'b1;
                    n_rsp   = '{block_id: '0, status: ST_FULL};
                    n_state = S_IDLE;
                end else begin
                    n_w  = r_w + WAW'(1);
                    n_wa = r_wa + AW'(WORD_BITS);
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_CLEAR;
            r_clr         <= '0;
            r_valid       <= 1'b0;
            r_group_count <= CFG_RESET;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_valid <= n_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_group_count <= i_cfg_data;
            end
        end
    end

    // Payload and scan registers
    always_ff @(posedge i_clk) begin
        r_req  <= n_req;
        r_rsp  <= n_rsp;
        r_w    <= n_w;
        r_wa   <= n_wa;
        r_best <= n_best;
        r_k    <= n_k;
    end

    // Bitmap memory, read at the next word index
    always_ff @(posedge i_clk) begin
        if (bm_we) begin
            bm_mem[bm_waddr] <= bm_wdata;
        end
        r_word_q <= bm_mem[n_w];
    end

    // Free count memory, read at the walker's next group
    always_ff @(posedge i_clk) begin
        if (cnt_we) begin
            cnt_mem[cnt_waddr] <= cnt_wdata;
        end
        r_cnt_q <= cnt_mem[w_g_nxt[GW-1:0]];
    end

    // Terms for the checks
    assign zh_acc   = accept && (i_req.cmd == CMD_ALLOC) && !i_req.first_alloc
                      && (i_req.hint_block == '0);
    assign run_acc  = accept && !zh_acc;
    assign rsp_fail = o_valid && (o_rsp.status != ST_OK);

    // Checks
    `AST_IMPLY(a_fail_zero_id, i_clk, i_rst_n, rsp_fail, o_rsp.block_id == '0)
    `AST_IMPLY(a_scan_in_group, i_clk, i_rst_n, r_state == S_WSCAN, w_g < gc)
    `AST_NEXT(a_zero_hint, i_clk, i_rst_n, zh_acc, o_valid && (o_rsp.status == ST_ZERO_HINT))
    `AST_NEXT(a_goes_busy, i_clk, i_rst_n, run_acc, busy && !o_valid)

endmodule

`default_nettype wire
